/* rtl/vmfd_pkg.sv */
package vmfd_pkg;

	localparam int MAX_PACKET_BYTES = 256;
	localparam int SKIP_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [SKIP_W-1:0] SKIP_DISCARD = SKIP_W'(MAX_PACKET_BYTES);

	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] VARINT_MAX_BYTES = CNT_W'(10);

	localparam int TDATA_W = 208;

	typedef enum logic [1:0] {
		PH_TAG,
		PH_VALUE,
		PH_LENGTH,
		PH_SKIP
	} phase_t;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LEN    = 3'd2;

	localparam logic [7:0] FLD_SPEED      = 8'd1;
	localparam logic [7:0] FLD_CADENCE    = 8'd2;
	localparam logic [7:0] FLD_POWER      = 8'd5;
	localparam logic [7:0] FLD_AMBIENT    = 8'd9;
	localparam logic [7:0] FLD_BATTERY    = 8'd10;
	localparam logic [7:0] FLD_ODOMETER   = 8'd12;
	localparam logic [7:0] FLD_LIGHT      = 8'd17;
	localparam logic [7:0] FLD_LOCKED     = 8'd21;
	localparam logic [7:0] FLD_STANDSTILL = 8'd25;
	localparam logic [7:0] FLD_WIDE       = 8'd255;

	typedef struct packed {
		logic        record_valid;
		logic [4:0]  status_flags;
		logic [7:0]  light_mode;
		logic [31:0] odometer_meters;
		logic [31:0] battery_percent;
		logic [31:0] ambient_millilux;
		logic [31:0] power_watts;
		logic [31:0] cadence_rpm;
		logic [31:0] speed_hundredths;
	} rec_t;

endpackage

/* rtl/vmfd_parser.sv */
module vmfd_parser import vmfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] payload_byte,
	input  logic       last_byte,
	output rec_t       rec_d
);

	phase_t             phase_q, phase_d;
	logic [31:0]        acc_q, acc_d;
	logic               hi_q, hi_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [7:0]         field_q, field_d;
	logic [SKIP_W-1:0]  skip_q, skip_d, skip_dec;
	rec_t               rec_q;

	logic [6:0]         sh;
	logic [63:0]        ext;
	logic [31:0]        g_acc;
	logic               g_hi;
	logic [CNT_W-1:0]   g_cnt;
	logic               done;

	logic               commit_en;
	logic [31:0]        c_lo;
	logic               c_hi;
	logic [31:0]        c_sat;
	logic [7:0]         c_light;
	logic               c_nz;
	logic [2:0]         flag_idx;

	// varint byte placement: 7 payload bits at 7 * byte count, bits past 63 dropped
	assign sh    = 7'(cnt_q) * 7'd7;
	assign ext   = 64'(payload_byte[6:0]) << sh;
	assign g_acc = acc_q | ext[31:0];
	assign g_hi  = hi_q | (|ext[63:32]);
	assign g_cnt = (cnt_q == VARINT_MAX_BYTES) ? cnt_q : cnt_q + CNT_W'(1);
	assign done  = !payload_byte[7];
	assign skip_dec = (skip_q != '0) ? skip_q - SKIP_W'(1) : skip_q;

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		hi_d      = hi_q;
		cnt_d     = cnt_q;
		field_d   = field_q;
		skip_d    = skip_q;
		commit_en = 1'b0;
		c_lo      = g_acc;
		c_hi      = g_hi;
		unique case (phase_q)
			PH_TAG: begin
				acc_d = g_acc;
				hi_d  = g_hi;
				cnt_d = g_cnt;
				if (done) begin
					field_d = (g_hi || (|g_acc[31:11])) ? FLD_WIDE : g_acc[10:3];
					acc_d = '0;
					hi_d  = 1'b0;
					cnt_d = '0;
					if (g_acc[2:0] == WT_VARINT) begin
						phase_d = PH_VALUE;
					end else if (g_acc[2:0] == WT_LEN) begin
						phase_d = PH_LENGTH;
					end else begin
						phase_d = PH_SKIP;
						skip_d  = SKIP_DISCARD;
					end
				end
			end
			PH_VALUE: begin
				acc_d = g_acc;
				hi_d  = g_hi;
				cnt_d = g_cnt;
				if (done) begin
					commit_en = 1'b1;
					acc_d   = '0;
					hi_d    = 1'b0;
					cnt_d   = '0;
					phase_d = PH_TAG;
				end
			end
			PH_LENGTH: begin
				acc_d = g_acc;
				hi_d  = g_hi;
				cnt_d = g_cnt;
				if (done) begin
					acc_d = '0;
					hi_d  = 1'b0;
					cnt_d = '0;
					if (g_acc == '0 && !g_hi) begin
						phase_d = PH_TAG;
					end else begin
						phase_d = PH_SKIP;
						skip_d  = (g_hi || g_acc >= 32'(MAX_PACKET_BYTES)) ?
							SKIP_DISCARD : g_acc[SKIP_W-1:0];
					end
				end
			end
			PH_SKIP: begin
				if (skip_q != SKIP_DISCARD) begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = PH_TAG;
					end
				end
			end
		endcase
		if (last_byte) begin
			// value cut short by packet end keeps the bits gathered so far
			if (phase_d == PH_VALUE) begin
				commit_en = 1'b1;
				c_lo = acc_d;
				c_hi = hi_d;
			end
			phase_d = PH_TAG;
			acc_d   = '0;
			hi_d    = 1'b0;
			cnt_d   = '0;
			skip_d  = '0;
		end
	end

	assign c_sat    = c_hi ? '1 : c_lo;
	assign c_light  = (c_hi || (|c_lo[31:8])) ? 8'hFF : c_lo[7:0];
	assign c_nz     = c_hi || (|c_lo);
	assign flag_idx = 3'(field_d - FLD_LOCKED);

	always_comb begin
		rec_d = rec_q;
		rec_d.record_valid = rec_q.record_valid | last_byte;
		if (commit_en) begin
			case (field_d)
				FLD_SPEED:    rec_d.speed_hundredths = c_sat;
				FLD_CADENCE:  rec_d.cadence_rpm      = c_lo;
				FLD_POWER:    rec_d.power_watts      = c_lo;
				FLD_AMBIENT:  rec_d.ambient_millilux = c_sat;
				FLD_BATTERY:  rec_d.battery_percent  = c_lo;
				FLD_ODOMETER: rec_d.odometer_meters  = c_sat;
				FLD_LIGHT:    rec_d.light_mode       = c_light;
				default: begin
					if (field_d >= FLD_LOCKED && field_d <= FLD_STANDSTILL) begin
						rec_d.status_flags[flag_idx] = c_nz;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q   <= '0;
			hi_q    <= 1'b0;
			cnt_q   <= '0;
			field_q <= '0;
			skip_q  <= '0;
			rec_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			hi_q    <= hi_d;
			cnt_q   <= cnt_d;
			field_q <= field_d;
			skip_q  <= skip_d;
			rec_q   <= rec_d;
		end
	end

endmodule

/* rtl/varint_message_field_decoder.sv */
// Streaming protobuf wire-format decoder: one payload byte per transaction on the s_ side,
// s_tlast marking the final byte of a packet. Tags, varint values and length-delimited
// bodies are parsed on the fly; values of the twelve known field numbers are kept in
// persistent registers, and on every last byte one full record transaction is issued on the
// m_ side. A byte is taken every cycle while s_tready is high: the parser decodes each
// byte combinationally into its state and store registers; a record sits in one output
// register, so s_tready only drops while a record waits and m_tready is low.
module varint_message_field_decoder import vmfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // payload_byte
	input  logic               s_tlast,   // last_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata    // speed_hundredths, cadence_rpm, power_watts,
	                                      // ambient_millilux, battery_percent,
	                                      // odometer_meters, light_mode, status_flags,
	                                      // record_valid, zero pad
);

	logic accept;
	rec_t rec_d;
	rec_t out_q;
	logic m_tvalid_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	vmfd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.payload_byte (s_tdata),
		.last_byte    (s_tlast),
		.rec_d        (rec_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept && s_tlast) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			out_q <= rec_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {
		2'b00,
		out_q.record_valid,
		out_q.status_flags,
		out_q.light_mode,
		out_q.odometer_meters,
		out_q.battery_percent,
		out_q.ambient_millilux,
		out_q.power_watts,
		out_q.cadence_rpm,
		out_q.speed_hundredths
	};

	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
		else $error("record issued without a last byte");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !(s_tvalid && s_tready && s_tlast)) |=> !m_tvalid)
		else $error("record repeated after transaction");

	a_valid_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[205])
		else $error("record issued with record_valid low");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
